>>> design/b32mul_pkg.sv
// ----------------------------------------------------------------------------
// b32mul_pkg
// Shared types for the binary32 multiplier: the operand class that travels
// down the pipeline beside the datapath.
// ----------------------------------------------------------------------------
package b32mul_pkg;

  typedef enum logic [1:0] {
    CLS_FINITE,
    CLS_ZERO,
    CLS_INF,
    CLS_NAN
  } cls_t;

endpackage

>>> design/binary32_multiply.sv
// ----------------------------------------------------------------------------
// binary32_multiply
// Pipelined IEEE 754 multiplier with round to nearest even.
// ----------------------------------------------------------------------------
// The block takes one operand pair per clock while in_stall is low and returns
// the products in request order. The five register stages are:
// unpack and normalize, partial products, product sum and alignment,
// denormalize, and round and pack. Each stage holds its request until the
// next stage has room, so bubbles close up under a stall. NaN results are
// always the canonical quiet NaN. The block has no configuration and keeps
// no state between requests.
module binary32_multiply #(
  parameter int EXP_WIDTH  = 8,
  parameter int FRAC_WIDTH = 23
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [EXP_WIDTH+FRAC_WIDTH:0]     in_operand_a,
  input  logic [EXP_WIDTH+FRAC_WIDTH:0]     in_operand_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [EXP_WIDTH+FRAC_WIDTH:0]     out_product_word
);

  localparam int E    = EXP_WIDTH;
  localparam int F    = FRAC_WIDTH;
  localparam int M    = F + 1;
  localparam int H    = (M + 1) / 2;
  localparam int LH   = M - H;
  localparam int PW   = 2 * M;
  localparam int XW   = E + 3;
  localparam int SW   = M + 3;
  localparam int SHW  = $clog2(SW + 1);
  localparam int LZW  = $clog2(M);
  localparam int BIAS = (1 << (E - 1)) - 1;
  localparam int FW   = E + F + 1;
  localparam logic [E-1:0] EXP_ONES = '1;

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign en5      = !v5_r || !out_stall;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // --------------------------------------------------------------------------
  // Stage 1: unpack, classify, normalize subnormal significands.
  // --------------------------------------------------------------------------
  logic               sa, sb;
  logic [E-1:0]       ea_raw, eb_raw;
  logic [F-1:0]       fa, fb;
  logic [M-1:0]       ma, mb;
  logic [LZW-1:0]     lza, lzb;
  b32mul_pkg::cls_t   cls1_nxt;
  logic [M-1:0]       ma1_nxt, mb1_nxt;
  logic signed [XW-1:0] ea1_nxt, eb1_nxt;

  assign sa     = in_operand_a[E+F];
  assign sb     = in_operand_b[E+F];
  assign ea_raw = in_operand_a[E+F-1:F];
  assign eb_raw = in_operand_b[E+F-1:F];
  assign fa     = in_operand_a[F-1:0];
  assign fb     = in_operand_b[F-1:0];
  assign ma     = {ea_raw != '0, fa};
  assign mb     = {eb_raw != '0, fb};

  always_comb begin
    lza = '0;
    lzb = '0;
    for (int i = 0; i < M; i++) begin
      if (ma[i]) begin
        lza = LZW'(M - 1 - i);
      end
      if (mb[i]) begin
        lzb = LZW'(M - 1 - i);
      end
    end
    ma1_nxt = ma << lza;
    mb1_nxt = mb << lzb;
    ea1_nxt = ((ea_raw == '0) ? XW'(1) : $signed({3'b000, ea_raw}))
              - $signed({{(XW - LZW){1'b0}}, lza});
    eb1_nxt = ((eb_raw == '0) ? XW'(1) : $signed({3'b000, eb_raw}))
              - $signed({{(XW - LZW){1'b0}}, lzb});
  end

  always_comb begin
    logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    nan_a  = (ea_raw == EXP_ONES) && (fa != '0);
    nan_b  = (eb_raw == EXP_ONES) && (fb != '0);
    inf_a  = (ea_raw == EXP_ONES) && (fa == '0);
    inf_b  = (eb_raw == EXP_ONES) && (fb == '0);
    zero_a = (ea_raw == '0) && (fa == '0);
    zero_b = (eb_raw == '0) && (fb == '0);
    priority if (nan_a || nan_b) begin
      cls1_nxt = b32mul_pkg::CLS_NAN;
    end else if (inf_a || inf_b) begin
      cls1_nxt = (zero_a || zero_b) ? b32mul_pkg::CLS_NAN : b32mul_pkg::CLS_INF;
    end else if (zero_a || zero_b) begin
      cls1_nxt = b32mul_pkg::CLS_ZERO;
    end else begin
      cls1_nxt = b32mul_pkg::CLS_FINITE;
    end
  end

  b32mul_pkg::cls_t     cls1_r, cls2_r, cls3_r, cls4_r;
  logic                 s1_r, s2_r, s3_r, s4_r;
  logic [M-1:0]         ma1_r, mb1_r;
  logic signed [XW-1:0] ea1_r, eb1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      cls1_r <= cls1_nxt;
      s1_r   <= sa ^ sb;
      ma1_r  <= ma1_nxt;
      mb1_r  <= mb1_nxt;
      ea1_r  <= ea1_nxt;
      eb1_r  <= eb1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: four half-width partial products, exponent sum.
  // --------------------------------------------------------------------------
  logic [2*H-1:0]       pll_nxt;
  logic [H+LH-1:0]      plh_nxt, phl_nxt;
  logic [2*LH-1:0]      phh_nxt;
  logic signed [XW-1:0] er2_nxt;

  assign pll_nxt = ma1_r[H-1:0] * mb1_r[H-1:0];
  assign plh_nxt = ma1_r[H-1:0] * mb1_r[M-1:H];
  assign phl_nxt = ma1_r[M-1:H] * mb1_r[H-1:0];
  assign phh_nxt = ma1_r[M-1:H] * mb1_r[M-1:H];
  assign er2_nxt = ea1_r + eb1_r - XW'(BIAS);

  logic [2*H-1:0]       pll_r;
  logic [H+LH-1:0]      plh_r, phl_r;
  logic [2*LH-1:0]      phh_r;
  logic signed [XW-1:0] er2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      cls2_r <= cls1_r;
      s2_r   <= s1_r;
      pll_r  <= pll_nxt;
      plh_r  <= plh_nxt;
      phl_r  <= phl_nxt;
      phh_r  <= phh_nxt;
      er2_r  <= er2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum partial products, align the leading one, collect sticky.
  // --------------------------------------------------------------------------
  logic [PW-1:0]        prod, norm;
  logic [SW-1:0]        sig3_nxt;
  logic signed [XW-1:0] er3_nxt;

  assign prod = (PW'(phh_r) << (2 * H)) + ((PW'(plh_r) + PW'(phl_r)) << H) + PW'(pll_r);
  assign norm = prod[PW-1] ? prod : (prod << 1);
  assign sig3_nxt = {norm[PW-1 -: M+2], |norm[M-3:0]};
  assign er3_nxt  = er2_r + (prod[PW-1] ? XW'(1) : XW'(0));

  logic [SW-1:0]        sig3_r;
  logic signed [XW-1:0] er3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      cls3_r <= cls2_r;
      s3_r   <= s2_r;
      sig3_r <= sig3_nxt;
      er3_r  <= er3_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: shift tiny results into subnormal position, keeping sticky.
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] gap;
  logic [SHW-1:0]       amt;
  logic [SW-1:0]        shifted, lost_mask;
  logic [SW-1:0]        sig4_nxt;
  logic signed [XW-1:0] er4_nxt;

  assign gap       = XW'(1) - er3_r;
  assign amt       = gap[SHW-1:0];
  assign shifted   = sig3_r >> amt;
  assign lost_mask = ~({SW{1'b1}} << amt);

  always_comb begin
    sig4_nxt = sig3_r;
    er4_nxt  = er3_r;
    if (er3_r <= XW'(0)) begin
      er4_nxt = '0;
      if (gap >= XW'(SW)) begin
        sig4_nxt = {{(SW - 1){1'b0}}, |sig3_r};
      end else begin
        sig4_nxt = {shifted[SW-1:1], shifted[0] | (|(sig3_r & lost_mask))};
      end
    end
  end

  logic [SW-1:0]        sig4_r;
  logic signed [XW-1:0] er4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      cls4_r <= cls3_r;
      s4_r   <= s3_r;
      sig4_r <= sig4_nxt;
      er4_r  <= er4_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: round to nearest even, overflow check, pack.
  // --------------------------------------------------------------------------
  logic [M-1:0]            rnd;
  logic [2:0]              rem;
  logic                    up;
  logic [M:0]              r1, r2;
  logic signed [XW-1:0]    er5;
  logic [FW-1:0]           field;
  logic [E+F:0]            word_nxt;

  assign rnd = sig4_r[SW-1:3];
  assign rem = sig4_r[2:0];
  assign up  = (rem > 3'd4) || ((rem == 3'd4) && rnd[0]);
  assign r1  = {1'b0, rnd} + (M+1)'(up);

  always_comb begin
    r2  = r1;
    er5 = er4_r;
    if ((er4_r > XW'(0)) && r1[M]) begin
      r2  = r1 >> 1;
      er5 = er4_r + XW'(1);
    end
    field = ((er5 == XW'(0)) ? FW'(0) : (FW'($unsigned(er5 - XW'(1))) << F)) + FW'(r2);
    unique case (cls4_r)
      b32mul_pkg::CLS_NAN:    word_nxt = {1'b0, EXP_ONES, 1'b1, {(F - 1){1'b0}}};
      b32mul_pkg::CLS_INF:    word_nxt = {s4_r, EXP_ONES, {F{1'b0}}};
      b32mul_pkg::CLS_ZERO:   word_nxt = {s4_r, {(E + F){1'b0}}};
      b32mul_pkg::CLS_FINITE: begin
        if (er5 >= $signed({3'b000, EXP_ONES})) begin
          word_nxt = {s4_r, EXP_ONES, {F{1'b0}}};
        end else begin
          word_nxt = {s4_r, field[E+F-1:0]};
        end
      end
      default:                word_nxt = {1'b0, EXP_ONES, 1'b1, {(F - 1){1'b0}}};
    endcase
  end

  logic [E+F:0] word_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      word_r <= word_nxt;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en5) begin
        v5_r <= v4_r;
      end
    end
  end

  assign out_valid        = v5_r;
  assign out_product_word = word_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted request did not enter the first stage");

  a_norm_a: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && (cls1_r == b32mul_pkg::CLS_FINITE) |-> ma1_r[M-1] && mb1_r[M-1])
    else $error("significand not normalized in the first stage");

  a_sig_top: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (cls3_r == b32mul_pkg::CLS_FINITE) |-> sig3_r[SW-1])
    else $error("aligned product lost its leading one");

  a_hold_stage4: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !en4 |=> v4_r && $stable(sig4_r))
    else $error("blocked stage four changed its request");

endmodule

>>> tb/binary32_multiply_tb.sv
// ----------------------------------------------------------------------------
// binary32_multiply_tb
// Self-checking bench for the pipelined binary32 multiplier. Operand pairs go
// in through the request channel under several idle and stall patterns; each
// product is predicted in the bench with an exact significand multiply and
// round to nearest even, and checked against the block in request order.
// ----------------------------------------------------------------------------
module binary32_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_W = 23;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_product_word;

  logic [31:0] expected_products[$];
  int          fail_count;
  int          checked_count;
  int          sent_count;
  int          cycle_count;
  int          send_idle_pct;
  int          stall_pct;

  binary32_multiply dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_product_word(out_product_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Exact product of two binary32 patterns, round to nearest even.
  function automatic logic [31:0] fp_product(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    int          ea, eb, er, top, sh;
    logic [23:0] ma, mb;
    logic [47:0] prod;
    logic [63:0] sig, rnd, rem;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    sgn = a[31] ^ b[31];
    ea = int'(a[30:23]);
    eb = int'(b[30:23]);
    ma = {1'b0, a[22:0]};
    mb = {1'b0, b[22:0]};
    nan_a = ea == 255 && ma != 0;
    nan_b = eb == 255 && mb != 0;
    inf_a = ea == 255 && ma == 0;
    inf_b = eb == 255 && mb == 0;
    zero_a = ea == 0 && ma == 0;
    zero_b = eb == 0 && mb == 0;
    if (nan_a || nan_b) return QNAN;
    if (inf_a || inf_b) return (zero_a || zero_b) ? QNAN : {sgn, 8'hFF, 23'd0};
    if (zero_a || zero_b) return {sgn, 31'd0};
    if (ea != 0) ma[23] = 1'b1; else ea = 1;
    if (eb != 0) mb[23] = 1'b1; else eb = 1;
    while (!ma[23]) begin
      ma = ma << 1;
      ea--;
    end
    while (!mb[23]) begin
      mb = mb << 1;
      eb--;
    end
    prod = ma * mb;
    er = ea + eb - 127;
    top = 46;
    if (prod[47]) begin
      top = 47;
      er++;
    end
    // Hidden bit, fraction and three guard bits, the last one sticky.
    sh = top - FRAC_W - 3;
    sig = 64'(prod >> sh);
    if ((prod & ((48'd1 << sh) - 1)) != 0) sig[0] = 1'b1;
    if (er <= 0) begin
      if (1 - er >= 63) sig = (sig != 0) ? 64'd1 : 64'd0;
      else sig = (sig >> (1 - er)) | 64'(((sig & ((64'd1 << (1 - er)) - 1)) != 0));
      er = 0;
    end
    rnd = sig >> 3;
    rem = sig & 64'd7;
    if (rem > 4 || (rem == 4 && rnd[0])) rnd++;
    if (er > 0 && (rnd >> (FRAC_W + 1)) != 0) begin
      rnd = rnd >> 1;
      er++;
    end
    if (er >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, 31'((er == 0 ? 64'd0 : (64'(er - 1) << FRAC_W)) + rnd)};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %08h expected %08h at cycle %0d", what, got, want,
             cycle_count);
    fail_count++;
  endtask

  // Valid stays high after a request; it is dropped only when the sender idles.
  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    expected_products.push_back(fp_product(a, b));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_products.size() == 0) begin
          report_mismatch("unexpected product", out_product_word, 32'h0);
        end else begin
          if (out_product_word !== expected_products[0])
            report_mismatch("product_word", out_product_word, expected_products[0]);
          void'(expected_products.pop_front());
          checked_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT) begin
      $display("Timeout with %0d products outstanding", expected_products.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] rand_operand();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0: w[30:23] = 8'd0;
      1: w[30:23] = 8'hFF;
      2: w[30:0] = 31'd0;
      3: w[30:23] = 8'($urandom_range(1, 20));
      4: w[30:23] = 8'($urandom_range(230, 254));
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_special_values();
    logic [31:0] vals[12];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
             32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
             32'h3F80_0000, 32'h7F7F_FFFF, 32'h0080_0000, 32'hBFC0_0001};
    for (int i = 0; i < 12; i++) send_pair(vals[i], vals[(i * 5 + 1) % 12]);
    send_pair(32'h7F80_0000, 32'h0000_0000);
    send_pair(32'h7F7F_FFFF, 32'h4000_0000);
    send_pair(32'h0080_0000, 32'h3F00_0000);
    send_pair(32'h0080_0001, 32'h3EFF_FFFF);
    send_pair(32'h0000_0001, 32'h3F00_0000);
    send_pair(32'h0000_0001, 32'h3F40_0000);
    send_pair(32'h3F80_0001, 32'h3F80_0001);
    send_pair(32'h007F_FFFF, 32'h3F80_0001);
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_pair(rand_operand(), rand_operand());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operand_a = '0;
    in_operand_b = '0;
    out_stall = 1'b0;
    fail_count = 0;
    checked_count = 0;
    sent_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_values();
    drain();
    test_random_phase(0, 0, 500);
    // The sender holds off here until the pipeline has emptied.
    drain();
    test_random_phase(71, 0, 500);
    test_random_phase(0, 71, 500);
    test_random_phase(21, 21, 500);
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    $display("Sent %0d requests through four idle and stall patterns; %0d products checked.",
             sent_count, checked_count);
    if (fail_count == 0 && expected_products.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> binary32_multiply.f
design/b32mul_pkg.sv
design/binary32_multiply.sv
tb/binary32_multiply_tb.sv
